/* rtl/core/rbd_pkg.sv */
// Package for the ring-buffer deque: beat types, action codes and defaults.
// Used by the modules under rtl/core except rbd_mem; depends on nothing.
package rbd_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int VALUE_W        = 32;
    localparam int OCC_W          = 11;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_POP_FRONT  = 2'd1,
        ACT_PUSH_BACK  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } action_t;

    // Input beat
    typedef struct packed {
        action_t                    action;
        logic signed [VALUE_W-1:0]  value;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic signed [VALUE_W-1:0]  popped_value;
        logic                       was_empty;
        logic                       matches_res;
        logic                       overflow;
        logic                       mismatch_seen;
        logic [OCC_W-1:0]           occupancy;
    } out_beat_t;

    // Per-item flags carried from the index stage to the result stage
    typedef struct packed {
        logic               is_pop;
        logic               empty;
        logic               ovf;
        logic [OCC_W-1:0]   occ;
    } item_flags_t;

endpackage

/* rtl/core/ring_buffer_deque.sv */
// Top level of the ring-buffer deque: index stage, entry RAM and result stage.
// Depends on rbd_pkg, rbd_ctrl, rbd_mem and rbd_out.
//
// Usage:
//   s_ channel: one beat per operation (push front, pop front, push back,
//   pop back) with a value that is pushed or, for a pop, the expected value.
//   m_ channel: exactly one result beat per input beat, in order: popped
//   value, empty and overflow flags, compare result, sticky mismatch flag
//   and the occupancy after the operation.
//   Throughput: one beat per cycle unless m_ready stalls. The single RAM
//   port serves the one write or read each operation needs; indices and
//   count update at accept. A result passes the registered RAM read and
//   the pending register, then the output register.
//   Stall: when m_ready is low the result beat holds; one more beat waits in
//   the pending stage, after which s_ready drops until the receiver drains.
//   Reset (aresetn low, synchronous): indices, count, sticky flag and both
//   valid stages clear; RAM contents are not cleared, no pop can read an
//   entry that was never pushed. No clearing pass: ready right after reset.
//   A push on a full deque is dropped and flagged, a pop on an empty deque
//   returns all ones and flags empty.
module ring_buffer_deque import rbd_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                  mem_we;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_addr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [DATA_WIDTH-1:0] mem_rdata;
    logic                  pend_valid;
    logic                  pend_take;
    item_flags_t           pend_flags;
    logic [DATA_WIDTH-1:0] pend_expect;

    rbd_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .mem_we      (mem_we),
        .mem_re      (mem_re),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata),
        .pend_valid  (pend_valid),
        .pend_take   (pend_take),
        .pend_flags  (pend_flags),
        .pend_expect (pend_expect)
    );

    rbd_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    rbd_out #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pend_valid  (pend_valid),
        .pend_take   (pend_take),
        .pend_flags  (pend_flags),
        .pend_expect (pend_expect),
        .mem_rdata   (mem_rdata),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

/* rtl/core/rbd_mem.sv */
// Entry store of the deque: single-port synchronous RAM with a registered read.
// Depends on nothing; read data holds until the next read.
module rbd_mem #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32,
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic                  re,
    input  logic [IDX_W-1:0]      addr,
    input  logic [DATA_WIDTH-1:0] wdata,
    output logic [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/rbd_ctrl.sv */
// Index stage of the deque: accepts beats, updates front/back/count, drives the RAM.
// Depends on rbd_pkg; feeds rbd_out through a one-entry pending register.
module rbd_ctrl import rbd_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    // RAM side
    output logic                  mem_we,
    output logic                  mem_re,
    output logic [IDX_W-1:0]      mem_addr,
    output logic [DATA_WIDTH-1:0] mem_wdata,
    // pending item toward result stage
    output logic                  pend_valid,
    input  logic                  pend_take,
    output item_flags_t           pend_flags,
    output logic [DATA_WIDTH-1:0] pend_expect
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [IDX_W-1:0]      front_reg, front_next;
    logic [IDX_W-1:0]      back_reg, back_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  pend_valid_reg, pend_valid_next;
    item_flags_t           flags_reg, flags_next;
    logic [DATA_WIDTH-1:0] expect_reg;
    logic [DATA_WIDTH-1:0] sval;
    logic                  accept;
    logic                  full, empty;

    assign s_ready = !pend_valid_reg || pend_take;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);

    // sign-extend or truncate the input value to the storage width
    assign sval = DATA_WIDTH'(s_data.value);

    // index update and RAM command
    always_comb begin
        front_next      = front_reg;
        back_next       = back_reg;
        count_next      = count_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = front_reg;
        flags_next      = flags_reg;
        pend_valid_next = pend_valid_reg && !pend_take;
        if (accept) begin
            pend_valid_next = 1'b1;
            flags_next.is_pop = (s_data.action == ACT_POP_FRONT) ||
                                (s_data.action == ACT_POP_BACK);
            flags_next.empty  = 1'b0;
            flags_next.ovf    = 1'b0;
            unique case (s_data.action)
                ACT_PUSH_FRONT: begin
                    if (full) begin
                        flags_next.ovf = 1'b1;
                    end else begin
                        front_next = (front_reg == '0) ? IDX_LAST : front_reg - 1'b1;
                        mem_addr   = front_next;
                        mem_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_PUSH_BACK: begin
                    if (full) begin
                        flags_next.ovf = 1'b1;
                    end else begin
                        mem_addr   = back_reg;
                        mem_we     = 1'b1;
                        back_next  = (back_reg == IDX_LAST) ? '0 : back_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_POP_FRONT: begin
                    if (empty) begin
                        flags_next.empty = 1'b1;
                    end else begin
                        mem_addr   = front_reg;
                        mem_re     = 1'b1;
                        front_next = (front_reg == IDX_LAST) ? '0 : front_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                ACT_POP_BACK: begin
                    if (empty) begin
                        flags_next.empty = 1'b1;
                    end else begin
                        back_next  = (back_reg == '0) ? IDX_LAST : back_reg - 1'b1;
                        mem_addr   = back_next;
                        mem_re     = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                default: begin
                    flags_next.ovf = 1'b0;
                end
            endcase
            flags_next.occ = OCC_W'(count_next);
        end
    end

    assign mem_wdata  = sval;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg      <= '0;
            back_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            front_reg      <= front_next;
            back_reg       <= back_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // pending payload
    always_ff @(posedge aclk) begin
        flags_reg <= flags_next;
        if (accept) begin
            expect_reg <= sval;
        end
    end

    assign pend_valid  = pend_valid_reg;
    assign pend_flags  = flags_reg;
    assign pend_expect = expect_reg;

endmodule

/* rtl/core/rbd_out.sv */
// Result stage of the deque: compares popped data, keeps the sticky flag, holds the beat.
// Depends on rbd_pkg; takes RAM read data and the pending item from rbd_ctrl.
module rbd_out import rbd_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  pend_valid,
    output logic                  pend_take,
    input  item_flags_t           pend_flags,
    input  logic [DATA_WIDTH-1:0] pend_expect,
    input  logic [DATA_WIDTH-1:0] mem_rdata,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data
);

    logic                  m_valid_reg, m_valid_next;
    logic                  sticky_reg, sticky_next;
    out_beat_t             beat_reg, beat_next;
    logic                  advance;
    logic [DATA_WIDTH-1:0] popped;
    logic [63:0]           popped_wide;
    logic                  match;

    assign advance   = !m_valid_reg || m_ready;
    assign pend_take = pend_valid && advance;

    // empty pops return all ones
    assign popped      = pend_flags.empty ? '1 : mem_rdata;
    assign popped_wide = 64'(popped);
    assign match       = !pend_flags.is_pop || (popped == pend_expect);

    // result beat
    always_comb begin
        beat_next    = beat_reg;
        sticky_next  = sticky_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (pend_take) begin
            m_valid_next           = 1'b1;
            sticky_next            = sticky_reg || !match;
            beat_next.popped_value = pend_flags.is_pop ? popped_wide[VALUE_W-1:0] : '0;
            beat_next.was_empty    = pend_flags.empty;
            beat_next.matches_res  = match;
            beat_next.overflow     = pend_flags.ovf;
            beat_next.mismatch_seen = sticky_next;
            beat_next.occupancy    = pend_flags.occ;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            sticky_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            sticky_reg  <= sticky_next;
        end
    end

    always_ff @(posedge aclk) begin
        beat_reg <= beat_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = beat_reg;

endmodule

/* rtl/core/rbd_checker.sv */
// Port-level checks for the ring-buffer deque, bound to the top level.
// Depends on rbd_pkg and ring_buffer_deque.
module rbd_checker import rbd_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_beat_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // sticky flag never falls once shown
    a_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.mismatch_seen |=> !m_valid || m_data.mismatch_seen)
        else $error("mismatch flag cleared");

    // overflow only when full, and never a mismatch
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.overflow |-> m_data.occupancy == OCC_FULL && m_data.matches_res)
        else $error("overflow with deque not full");

    // empty pop leaves the deque empty and is no overflow
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.was_empty |-> m_data.occupancy == '0 && !m_data.overflow)
        else $error("empty pop with entries held");

    // reset leaves no result pending
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind ring_buffer_deque rbd_checker #(.DEPTH(DEPTH)) u_rbd_checker (.*);

/* dv/rbd_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for the ring-buffer deque: follows accepted beats on both channels,
// keeps its own deque to predict every result beat and compares it field by field.
// Depends on rbd_pkg.
module rbd_result_checker import rbd_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_beat_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_beat_t m_data,
    output int        fail_count,
    output int        awaited_count
);

    // Predicted deque contents and bookkeeping
    logic [DATA_WIDTH-1:0] entries [DEPTH];
    int                    head_idx;
    int                    tail_idx;
    int                    held;
    logic                  sticky_bad;
    out_beat_t             awaited_beats [$];

    initial begin
        fail_count    = 0;
        awaited_count = 0;
        head_idx      = 0;
        tail_idx      = 0;
        held          = 0;
        sticky_bad    = 1'b0;
    end

    // Apply one operation to the predicted deque and return the result beat it gives
    function automatic out_beat_t apply_deque_op(in_beat_t op);
        out_beat_t             res;
        logic signed [63:0]    wide_in;
        logic [63:0]           wide_out;
        logic [DATA_WIDTH-1:0] want;
        logic [DATA_WIDTH-1:0] got;
        wide_in = op.value;                 // sign-extends
        want    = wide_in[DATA_WIDTH-1:0];
        got     = '0;
        res     = '0;
        res.matches_res = 1'b1;
        if (op.action == ACT_PUSH_FRONT || op.action == ACT_PUSH_BACK) begin
            if (held >= DEPTH) begin
                res.overflow = 1'b1;        // full: dropped, nothing moves
            end else if (op.action == ACT_PUSH_FRONT) begin
                head_idx = (head_idx == 0) ? DEPTH - 1 : head_idx - 1;
                entries[head_idx] = want;
                held++;
            end else begin
                entries[tail_idx] = want;
                tail_idx = (tail_idx == DEPTH - 1) ? 0 : tail_idx + 1;
                held++;
            end
        end else begin
            if (held == 0) begin
                got           = '1;         // empty pop reads all ones
                res.was_empty = 1'b1;
            end else if (op.action == ACT_POP_FRONT) begin
                got      = entries[head_idx];
                head_idx = (head_idx == DEPTH - 1) ? 0 : head_idx + 1;
                held--;
            end else begin
                tail_idx = (tail_idx == 0) ? DEPTH - 1 : tail_idx - 1;
                got      = entries[tail_idx];
                held--;
            end
            res.matches_res = (got == want);
            if (!res.matches_res)
                sticky_bad = 1'b1;
        end
        wide_out          = 64'(got);
        res.popped_value  = wide_out[31:0];
        res.mismatch_seen = sticky_bad;
        res.occupancy     = OCC_W'(held);
        return res;
    endfunction

    // Compare result beats with the oldest prediction, then record new input beats
    always @(posedge aclk) begin : watch
        out_beat_t want;
        if (!aresetn) begin
            head_idx   = 0;
            tail_idx   = 0;
            held       = 0;
            sticky_bad = 1'b0;
            awaited_beats.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_beats.size() == 0) begin
                    $error("result beat with nothing awaited: %p", m_data);
                    fail_count++;
                end else begin
                    want = awaited_beats[0];
                    awaited_beats.delete(0);
                    if (m_data.popped_value !== want.popped_value) begin
                        $error("popped_value: expected 0x%h, got 0x%h",
                               want.popped_value, m_data.popped_value);
                        fail_count++;
                    end
                    if (m_data.was_empty !== want.was_empty) begin
                        $error("was_empty: expected %b, got %b",
                               want.was_empty, m_data.was_empty);
                        fail_count++;
                    end
                    if (m_data.matches_res !== want.matches_res) begin
                        $error("matches_res: expected %b, got %b",
                               want.matches_res, m_data.matches_res);
                        fail_count++;
                    end
                    if (m_data.overflow !== want.overflow) begin
                        $error("overflow: expected %b, got %b",
                               want.overflow, m_data.overflow);
                        fail_count++;
                    end
                    if (m_data.mismatch_seen !== want.mismatch_seen) begin
                        $error("mismatch_seen: expected %b, got %b",
                               want.mismatch_seen, m_data.mismatch_seen);
                        fail_count++;
                    end
                    if (m_data.occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, m_data.occupancy);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                awaited_beats = {awaited_beats, apply_deque_op(s_data)};
        end
        awaited_count = awaited_beats.size();
    end

endmodule

/* dv/tb_ring_buffer_deque.sv */
`timescale 1ns / 100ps
// Testbench top for the ring-buffer deque: clock, reset, operation stimulus with
// bursty input and stalling output, watchdog and verdict. Depends on rbd_pkg,
// ring_buffer_deque and rbd_result_checker.
module tb_ring_buffer_deque import rbd_pkg::*;;

    localparam int STALL_LIMIT = 2000;  // cycles without any accepted beat
    localparam int LONG_HOLD   = 300;   // receiver hold-off while the deque backs up

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    int        fail_count;
    int        awaited_count;
    int        idle_cycles = 0;
    int        burst_left;
    bit        hold_req;

    // Values the stimulus believes are held, front first; used to pick expectations
    logic signed [31:0] held_values [$];

    ring_buffer_deque dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    rbd_result_checker result_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .awaited_count (awaited_count)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Watchdog: end the run when no beat moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $error("no beat accepted for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: segments of steady, random and periodic stalls, one long hold-off
    initial begin : receiver
        int mode;
        int seg_len;
        int period;
        bit hold_taken;
        hold_taken = 1'b0;
        m_ready    = 1'b0;
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                repeat (LONG_HOLD) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(20, 150);
            period  = $urandom_range(2, 6);
            for (int c = 0; c < seg_len; c++) begin
                @(negedge aclk);
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 2) != 0);
                    2:       m_ready <= ((c % period) != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Field values biased toward the extremes
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            3:       return 32'sd0;
            4:       return $signed(32'($urandom_range(0, 15)));
            default: return $signed($urandom());
        endcase
    endfunction

    // Expected value for a pop; wrong_pct percent of them get a flipped bit
    function automatic logic signed [31:0] pop_expect(action_t act, int wrong_pct);
        logic signed [31:0] v;
        if (held_values.size() == 0)
            v = -32'sd1;
        else if (act == ACT_POP_FRONT)
            v = held_values[0];
        else
            v = held_values[held_values.size() - 1];
        if ($urandom_range(0, 99) < wrong_pct)
            v = v ^ (32'h1 << $urandom_range(0, 31));
        return v;
    endfunction

    // Offer one beat in the current burst; start a new burst, maybe after a gap
    task automatic send_beat(action_t act, logic signed [31:0] v);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(40, 120);
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(0, 6);
            end
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= '{action: act, value: v};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Track the operation in the held values, then send it
    task automatic issue_op(action_t act, logic signed [31:0] v);
        case (act)
            ACT_PUSH_FRONT: if (held_values.size() < DEPTH_DEF) held_values = {v, held_values};
            ACT_PUSH_BACK:  if (held_values.size() < DEPTH_DEF) held_values = {held_values, v};
            ACT_POP_FRONT:  if (held_values.size() > 0) held_values.delete(0);
            default:        if (held_values.size() > 0)
                                held_values.delete(held_values.size() - 1);
        endcase
        send_beat(act, v);
    endtask

    task automatic random_op(int push_pct, int wrong_pct);
        action_t act;
        if ($urandom_range(0, 99) < push_pct) begin
            act = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
            issue_op(act, pick_value());
        end else begin
            act = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
            issue_op(act, pop_expect(act, wrong_pct));
        end
    endtask

    // Stop offering until every awaited result beat has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (awaited_count != 0);
    endtask

    initial begin : stimulus
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        hold_req   = 1'b0;
        burst_left = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty pops, extreme values, both ends, index wrap below zero
        issue_op(ACT_POP_FRONT, -32'sd1);
        issue_op(ACT_POP_BACK, -32'sd1);
        issue_op(ACT_PUSH_FRONT, 32'sh7fff_ffff);
        issue_op(ACT_PUSH_BACK, 32'sh8000_0000);
        issue_op(ACT_PUSH_FRONT, -32'sd1);
        issue_op(ACT_PUSH_BACK, 32'sd0);
        issue_op(ACT_POP_BACK, pop_expect(ACT_POP_BACK, 0));
        issue_op(ACT_POP_FRONT, pop_expect(ACT_POP_FRONT, 0));
        issue_op(ACT_POP_FRONT, pop_expect(ACT_POP_FRONT, 0));
        issue_op(ACT_POP_BACK, pop_expect(ACT_POP_BACK, 0));
        issue_op(ACT_PUSH_BACK, 32'sh5555_5555);
        issue_op(ACT_PUSH_FRONT, 32'shaaaa_aaaa);
        issue_op(ACT_POP_FRONT, pop_expect(ACT_POP_FRONT, 0));
        issue_op(ACT_POP_FRONT, pop_expect(ACT_POP_FRONT, 0));
        issue_op(ACT_PUSH_BACK, 32'sd1);
        issue_op(ACT_POP_BACK, pop_expect(ACT_POP_BACK, 0));
        drain_results();

        // Short balanced mix near empty, all expectations correct: sticky flag stays low
        repeat (10) random_op(50, 0);
        drain_results();

        // Fill to capacity while the receiver holds off, push into a full deque, then pop one and push again
        hold_req = 1'b1;
        while (held_values.size() < DEPTH_DEF) random_op(100, 0);
        repeat (8) random_op(100, 0);
        issue_op(ACT_POP_FRONT, pop_expect(ACT_POP_FRONT, 0));
        repeat (2) random_op(100, 0);
        drain_results();

        // Pops from full with wrong expectations, then mixed traffic with the sticky flag set
        issue_op(ACT_POP_BACK, pop_expect(ACT_POP_BACK, 100));
        repeat (10) random_op(0, 30);
        repeat (10) random_op(50, 5);
        drain_results();
        repeat (10) @(negedge aclk);

        if (fail_count == 0 && awaited_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/rbd_pkg.sv
rtl/core/rbd_mem.sv
rtl/core/rbd_ctrl.sv
rtl/core/rbd_out.sv
rtl/core/ring_buffer_deque.sv
rtl/core/rbd_checker.sv
dv/rbd_result_checker.sv
dv/tb_ring_buffer_deque.sv
